@@ rtl/core/acr_pkg.sv @@
// ---------------------------------------------------------------------------
// acr_pkg
// Shared types and constants for the box collision resolver: controller
// states, pass codes, object class and kind codes, command and status bundles.
// ---------------------------------------------------------------------------
package acr_pkg;

	// default sizes
	localparam int MAX_OBJECTS_DEF = 32;
	localparam int COORD_BITS_DEF  = 24;

	// object class codes
	localparam logic [1:0] CLS_DYNAMIC = 2'd0;
	localparam logic [1:0] CLS_STATIC  = 2'd1;
	localparam logic [1:0] CLS_MOVED   = 2'd2;

	// collider kind codes
	localparam logic [1:0] KIND_PLAYER = 2'd1;
	localparam logic [1:0] KIND_ENEMY  = 2'd2;

	// resolution passes, in run order
	typedef enum logic [1:0] {
		PASS_DS,
		PASS_DM,
		PASS_MM,
		PASS_MS
	} pass_t;

	// controller states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD_I,
		ST_CHK_I,
		ST_RD_J,
		ST_CHK_J,
		ST_EDGE,
		ST_VEC,
		ST_SEL,
		ST_AXIS,
		ST_UPD,
		ST_WR_I,
		ST_WR_J,
		ST_OUT_RD,
		ST_OUT
	} state_t;

	// source of the store write word
	typedef enum logic [1:0] {
		WSEL_LOAD,
		WSEL_I,
		WSEL_J
	} wsel_t;

	// controller to datapath
	typedef struct packed {
		logic  re;
		logic  we;
		wsel_t wsel;
		logic  ld_a;
		logic  ld_b;
		logic  split;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] a_kind;
		logic [1:0] rd_cls;
		logic [1:0] rd_kind;
		logic       overlap;
	} status_t;

endpackage

@@ rtl/core/acr_ram.sv @@
// ---------------------------------------------------------------------------
// acr_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module acr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/acr_dpath.sv @@
// ---------------------------------------------------------------------------
// acr_dpath
// Object store and pair arithmetic: box edges, overlap test, minimum
// translation vector, push and saturation, write-back words.
// ---------------------------------------------------------------------------
module acr_dpath #(
	parameter int MAX_OBJECTS = acr_pkg::MAX_OBJECTS_DEF,
	parameter int COORD_BITS  = acr_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  acr_pkg::cmd_t                  cmd,
	input  logic [$clog2(MAX_OBJECTS)-1:0] ram_addr,
	input  logic signed [COORD_BITS-1:0]   center_x,
	input  logic signed [COORD_BITS-1:0]   center_y,
	input  logic [COORD_BITS-2:0]          box_width,
	input  logic [COORD_BITS-2:0]          box_height,
	input  logic [1:0]                     object_class,
	input  logic [1:0]                     collider_kind,
	output acr_pkg::status_t               sts,
	output logic signed [COORD_BITS-1:0]   new_x,
	output logic signed [COORD_BITS-1:0]   new_y
);

	localparam int CW     = COORD_BITS;
	localparam int WORD_W = 2 * CW + 2 * (CW - 1) + 4;

	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;

	logic signed [CW-1:0] rd_x, rd_y;
	logic [CW-2:0]        rd_w, rd_h;
	logic [1:0]           rd_cls, rd_kind;

	logic signed [CW-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	logic [CW-2:0]        a_w_q, a_h_q, b_w_q, b_h_q;
	logic [1:0]           a_cls_q, a_kind_q, b_cls_q, b_kind_q;

	logic signed [CW:0]   ax0_s1, ax1_s1, ay0_s1, ay1_s1;
	logic signed [CW:0]   bx0_s1, bx1_s1, by0_s1, by1_s1;
	logic signed [CW+1:0] dx1_s2, dx2_s2, dy1_s2, dy2_s2;
	logic                 overlap_s2;
	logic [CW+1:0]        mdx1, mdx2, mdy1, mdy2;
	logic signed [CW+1:0] vx_s3, vy_s3;
	logic [CW+1:0]        mvx, mvy;
	logic signed [CW+1:0] mx_s4, my_s4;
	logic signed [CW+1:0] px, py;
	logic signed [CW+2:0] sum_ix, sum_iy, sum_jx, sum_jy;
	logic signed [CW-1:0] nix_s5, niy_s5, njx_s5, njy_s5;

	// clamp a wide sum to the coordinate range
	function automatic logic signed [CW-1:0] sat_fn(input logic signed [CW+2:0] v);
		logic ovf;
		ovf = !((&v[CW+2:CW-1]) || !(|v[CW+2:CW-1]));
		if (!ovf) begin
			sat_fn = v[CW-1:0];
		end else if (v[CW+2]) begin
			sat_fn = {1'b1, {(CW-1){1'b0}}};
		end else begin
			sat_fn = {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	// magnitude of a difference
	function automatic logic [CW+1:0] mag_fn(input logic signed [CW+1:0] v);
		mag_fn = v[CW+1] ? -v : v;
	endfunction

	// store word layout: x, y, width, height, class, kind
	assign {rd_x, rd_y, rd_w, rd_h, rd_cls, rd_kind} = rdata;

	// write word select
	always_comb begin
		case (cmd.wsel)
			acr_pkg::WSEL_I: wdata = {nix_s5, niy_s5, a_w_q, a_h_q, a_cls_q, a_kind_q};
			acr_pkg::WSEL_J: wdata = {njx_s5, njy_s5, b_w_q, b_h_q, b_cls_q, b_kind_q};
			default:         wdata = {center_x, center_y, box_width, box_height,
			                          object_class, collider_kind};
		endcase
	end

	acr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_OBJECTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(ram_addr),
		.wdata(wdata),
		.re   (cmd.re),
		.raddr(ram_addr),
		.rdata(rdata)
	);

	// first box of the pair, refreshed on its own write-back
	always_ff @(posedge clk) begin
		if (cmd.ld_a) begin
			a_x_q    <= rd_x;
			a_y_q    <= rd_y;
			a_w_q    <= rd_w;
			a_h_q    <= rd_h;
			a_cls_q  <= rd_cls;
			a_kind_q <= rd_kind;
		end else if (cmd.we && cmd.wsel == acr_pkg::WSEL_I) begin
			a_x_q <= nix_s5;
			a_y_q <= niy_s5;
		end
	end

	// second box of the pair
	always_ff @(posedge clk) begin
		if (cmd.ld_b) begin
			b_x_q    <= rd_x;
			b_y_q    <= rd_y;
			b_w_q    <= rd_w;
			b_h_q    <= rd_h;
			b_cls_q  <= rd_cls;
			b_kind_q <= rd_kind;
		end
	end

	// stage 1: box edges
	always_ff @(posedge clk) begin
		ax0_s1 <= $signed({a_x_q[CW-1], a_x_q}) - $signed({3'b000, a_w_q[CW-2:1]});
		ax1_s1 <= $signed({a_x_q[CW-1], a_x_q}) + $signed({3'b000, a_w_q[CW-2:1]});
		ay0_s1 <= $signed({a_y_q[CW-1], a_y_q}) - $signed({3'b000, a_h_q[CW-2:1]});
		ay1_s1 <= $signed({a_y_q[CW-1], a_y_q}) + $signed({3'b000, a_h_q[CW-2:1]});
		bx0_s1 <= $signed({b_x_q[CW-1], b_x_q}) - $signed({3'b000, b_w_q[CW-2:1]});
		bx1_s1 <= $signed({b_x_q[CW-1], b_x_q}) + $signed({3'b000, b_w_q[CW-2:1]});
		by0_s1 <= $signed({b_y_q[CW-1], b_y_q}) - $signed({3'b000, b_h_q[CW-2:1]});
		by1_s1 <= $signed({b_y_q[CW-1], b_y_q}) + $signed({3'b000, b_h_q[CW-2:1]});
	end

	// stage 2: candidate vectors and overlap, edge contact counts
	always_ff @(posedge clk) begin
		dx1_s2     <= $signed({bx1_s1[CW], bx1_s1}) - $signed({ax0_s1[CW], ax0_s1});
		dx2_s2     <= $signed({bx0_s1[CW], bx0_s1}) - $signed({ax1_s1[CW], ax1_s1});
		dy1_s2     <= $signed({by1_s1[CW], by1_s1}) - $signed({ay0_s1[CW], ay0_s1});
		dy2_s2     <= $signed({by0_s1[CW], by0_s1}) - $signed({ay1_s1[CW], ay1_s1});
		overlap_s2 <= !(ax1_s1 < bx0_s1 || ax0_s1 > bx1_s1 ||
		                ay1_s1 < by0_s1 || ay0_s1 > by1_s1);
	end

	// stage 3: smaller candidate per axis, ties to the second
	assign mdx1 = mag_fn(dx1_s2);
	assign mdx2 = mag_fn(dx2_s2);
	assign mdy1 = mag_fn(dy1_s2);
	assign mdy2 = mag_fn(dy2_s2);

	always_ff @(posedge clk) begin
		vx_s3 <= (mdx1 < mdx2) ? dx1_s2 : dx2_s2;
		vy_s3 <= (mdy1 < mdy2) ? dy1_s2 : dy2_s2;
	end

	// stage 4: smaller axis, ties to y
	assign mvx = mag_fn(vx_s3);
	assign mvy = mag_fn(vy_s3);

	always_ff @(posedge clk) begin
		if (mvx < mvy) begin
			mx_s4 <= vx_s3;
			my_s4 <= '0;
		end else begin
			mx_s4 <= '0;
			my_s4 <= vy_s3;
		end
	end

	// stage 5: full push or half split, then clamp
	assign px     = cmd.split ? (mx_s4 >>> 1) : mx_s4;
	assign py     = cmd.split ? (my_s4 >>> 1) : my_s4;
	assign sum_ix = $signed({{3{a_x_q[CW-1]}}, a_x_q}) + $signed({px[CW+1], px});
	assign sum_iy = $signed({{3{a_y_q[CW-1]}}, a_y_q}) + $signed({py[CW+1], py});
	assign sum_jx = $signed({{3{b_x_q[CW-1]}}, b_x_q}) - $signed({px[CW+1], px});
	assign sum_jy = $signed({{3{b_y_q[CW-1]}}, b_y_q}) - $signed({py[CW+1], py});

	always_ff @(posedge clk) begin
		nix_s5 <= sat_fn(sum_ix);
		niy_s5 <= sat_fn(sum_iy);
		njx_s5 <= sat_fn(sum_jx);
		njy_s5 <= sat_fn(sum_jy);
	end

	// status and result fields
	assign sts.a_kind  = a_kind_q;
	assign sts.rd_cls  = rd_cls;
	assign sts.rd_kind = rd_kind;
	assign sts.overlap = overlap_s2;
	assign new_x       = rd_x;
	assign new_y       = rd_y;

endmodule

@@ rtl/core/acr_ctrl.sv @@
// ---------------------------------------------------------------------------
// acr_ctrl
// Sequencer for loading, the four ordered resolution passes and the
// report of every object; holds the object count and the config register.
// ---------------------------------------------------------------------------
module acr_ctrl #(
	parameter int MAX_OBJECTS = acr_pkg::MAX_OBJECTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           final_object,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           cfg_write_en,
	input  logic                           cfg_write_data,
	input  acr_pkg::status_t               sts,
	output acr_pkg::cmd_t                  cmd,
	output logic [$clog2(MAX_OBJECTS)-1:0] ram_addr,
	output logic [$clog2(MAX_OBJECTS)-1:0] object_number,
	output logic                           end_of_run
);

	localparam int IDX_W = $clog2(MAX_OBJECTS);
	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

	acr_pkg::state_t state_q, state_d;
	acr_pkg::pass_t  pass_q, pass_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
	logic [CNT_W-1:0] i_inc, j_inc;
	logic             inv_q;
	logic             full, i_last, j_last, i_ok, j_ok, pe, split;
	logic             adv_i, adv_j;

	assign i_inc  = i_q + CNT_W'(1);
	assign j_inc  = j_q + CNT_W'(1);
	assign i_last = (i_inc >= cnt_q);
	assign j_last = (j_inc >= cnt_q);
	assign full   = (cnt_q == CNT_W'(MAX_OBJECTS));
	assign pe     = (sts.a_kind == acr_pkg::KIND_PLAYER) &&
	                (sts.rd_kind == acr_pkg::KIND_ENEMY);
	assign split  = (pass_q == acr_pkg::PASS_DM) || (pass_q == acr_pkg::PASS_MM);

	// pair filters per pass
	always_comb begin
		unique case (pass_q)
			acr_pkg::PASS_DS: begin
				i_ok = (sts.rd_cls == acr_pkg::CLS_DYNAMIC);
				j_ok = (sts.rd_cls == acr_pkg::CLS_STATIC) && !pe;
			end
			acr_pkg::PASS_DM: begin
				i_ok = (sts.rd_cls == acr_pkg::CLS_DYNAMIC);
				j_ok = (sts.rd_cls == acr_pkg::CLS_MOVED) && !(inv_q && pe);
			end
			acr_pkg::PASS_MM: begin
				i_ok = (sts.rd_cls == acr_pkg::CLS_MOVED);
				j_ok = (sts.rd_cls == acr_pkg::CLS_MOVED);
			end
			default: begin
				i_ok = (sts.rd_cls == acr_pkg::CLS_MOVED);
				j_ok = (sts.rd_cls == acr_pkg::CLS_STATIC);
			end
		endcase
	end

	// next state and loop counters
	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		j_d     = j_q;
		adv_i   = 1'b0;
		adv_j   = 1'b0;
		unique case (state_q)
			acr_pkg::ST_LOAD: begin
				if (in_valid) begin
					if (!full) cnt_d = cnt_q + CNT_W'(1);
					if (final_object) begin
						state_d = acr_pkg::ST_RD_I;
						pass_d  = acr_pkg::PASS_DS;
						i_d     = '0;
					end
				end
			end
			acr_pkg::ST_RD_I: state_d = acr_pkg::ST_CHK_I;
			acr_pkg::ST_CHK_I: begin
				if (i_ok && (pass_q != acr_pkg::PASS_MM || !i_last)) begin
					j_d     = (pass_q == acr_pkg::PASS_MM) ? i_inc : '0;
					state_d = acr_pkg::ST_RD_J;
				end else begin
					adv_i = 1'b1;
				end
			end
			acr_pkg::ST_RD_J: state_d = acr_pkg::ST_CHK_J;
			acr_pkg::ST_CHK_J: begin
				if (j_ok) state_d = acr_pkg::ST_EDGE;
				else adv_j = 1'b1;
			end
			acr_pkg::ST_EDGE: state_d = acr_pkg::ST_VEC;
			acr_pkg::ST_VEC:  state_d = acr_pkg::ST_SEL;
			acr_pkg::ST_SEL:  state_d = acr_pkg::ST_AXIS;
			acr_pkg::ST_AXIS: begin
				if (sts.overlap) state_d = acr_pkg::ST_UPD;
				else adv_j = 1'b1;
			end
			acr_pkg::ST_UPD: state_d = acr_pkg::ST_WR_I;
			acr_pkg::ST_WR_I: begin
				if (split) state_d = acr_pkg::ST_WR_J;
				else adv_j = 1'b1;
			end
			acr_pkg::ST_WR_J: adv_j = 1'b1;
			acr_pkg::ST_OUT_RD: state_d = acr_pkg::ST_OUT;
			acr_pkg::ST_OUT: begin
				if (!out_stall) begin
					if (i_last) begin
						state_d = acr_pkg::ST_LOAD;
						cnt_d   = '0;
					end else begin
						i_d     = i_inc;
						state_d = acr_pkg::ST_OUT_RD;
					end
				end
			end
			default: state_d = acr_pkg::ST_LOAD;
		endcase

		// step the pair loops
		if (adv_j && !j_last) begin
			j_d     = j_inc;
			state_d = acr_pkg::ST_RD_J;
		end else if (adv_j || adv_i) begin
			i_d = '0;
			if (!i_last) begin
				i_d     = i_inc;
				state_d = acr_pkg::ST_RD_I;
			end else begin
				unique case (pass_q)
					acr_pkg::PASS_DS: pass_d = acr_pkg::PASS_DM;
					acr_pkg::PASS_DM: pass_d = acr_pkg::PASS_MM;
					acr_pkg::PASS_MM: pass_d = acr_pkg::PASS_MS;
					default:          pass_d = acr_pkg::PASS_MS;
				endcase
				state_d = (pass_q == acr_pkg::PASS_MS) ? acr_pkg::ST_OUT_RD
				                                       : acr_pkg::ST_RD_I;
			end
		end
	end

	// outputs and datapath commands
	always_comb begin
		cmd.re    = 1'b0;
		cmd.we    = 1'b0;
		cmd.wsel  = acr_pkg::WSEL_LOAD;
		cmd.ld_a  = 1'b0;
		cmd.ld_b  = 1'b0;
		cmd.split = split;
		ram_addr  = i_q[IDX_W-1:0];
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q) inside
			acr_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				cmd.we   = in_valid && !full;
				ram_addr = cnt_q[IDX_W-1:0];
			end
			acr_pkg::ST_RD_I, acr_pkg::ST_OUT_RD: cmd.re = 1'b1;
			acr_pkg::ST_CHK_I: cmd.ld_a = 1'b1;
			acr_pkg::ST_RD_J: begin
				cmd.re   = 1'b1;
				ram_addr = j_q[IDX_W-1:0];
			end
			acr_pkg::ST_CHK_J: cmd.ld_b = 1'b1;
			acr_pkg::ST_WR_I: begin
				cmd.we   = 1'b1;
				cmd.wsel = acr_pkg::WSEL_I;
			end
			acr_pkg::ST_WR_J: begin
				cmd.we   = 1'b1;
				cmd.wsel = acr_pkg::WSEL_J;
				ram_addr = j_q[IDX_W-1:0];
			end
			acr_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign object_number = i_q[IDX_W-1:0];
	assign end_of_run    = i_last;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acr_pkg::ST_LOAD;
			pass_q  <= acr_pkg::PASS_DS;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	// invincibility register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
		end else if (cfg_write_en) begin
			inv_q <= cfg_write_data;
		end
	end

endmodule

@@ rtl/core/aabb_collision_resolver_unit.sv @@
// ---------------------------------------------------------------------------
// aabb_collision_resolver_unit
// Loads axis-aligned boxes, resolves overlaps by minimum translation vector
// in four ordered passes and reports every resolved centre in load order.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one box per cycle while loading.
//   The transaction with final_object set starts resolution; in_stall stays
//   high from then until the last result is taken.
//   Resolution walks every candidate pair from one shared store port: a pair
//   rejected on class or kind is only read and loaded; a pair that does not
//   overlap goes through read j, load j and four arithmetic stages; a pushed
//   pair adds the update and the write-back of i, and a split the second
//   write-back; each object start reads and loads i.
//   Output channel (out_valid/out_stall) then gives N transactions, one at a
//   time, each read from the store read port; end_of_run marks the last. A
//   stall simply holds the current result.
//   cfg_write_en/cfg_write_data set player_invincible; write only when idle.
//   Reset clears the object count, the sequencer and player_invincible; the
//   store needs no clearing since only loaded entries are read.
// ---------------------------------------------------------------------------
module aabb_collision_resolver_unit #(
	parameter int MAX_OBJECTS = acr_pkg::MAX_OBJECTS_DEF,
	parameter int COORD_BITS  = acr_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_BITS-1:0]   center_x,
	input  logic signed [COORD_BITS-1:0]   center_y,
	input  logic [COORD_BITS-2:0]          box_width,
	input  logic [COORD_BITS-2:0]          box_height,
	input  logic [1:0]                     object_class,
	input  logic [1:0]                     collider_kind,
	input  logic                           final_object,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [$clog2(MAX_OBJECTS)-1:0] object_number,
	output logic signed [COORD_BITS-1:0]   new_x,
	output logic signed [COORD_BITS-1:0]   new_y,
	output logic                           end_of_run,
	input  logic                           cfg_write_en,
	input  logic                           cfg_write_data
);

	acr_pkg::cmd_t    cmd;
	acr_pkg::status_t sts;
	logic [$clog2(MAX_OBJECTS)-1:0] ram_addr;

	// sequencer
	acr_ctrl #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.final_object  (final_object),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.sts           (sts),
		.cmd           (cmd),
		.ram_addr      (ram_addr),
		.object_number (object_number),
		.end_of_run    (end_of_run)
	);

	// store and pair arithmetic
	acr_dpath #(
		.MAX_OBJECTS(MAX_OBJECTS),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.ram_addr     (ram_addr),
		.center_x     (center_x),
		.center_y     (center_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.object_class (object_class),
		.collider_kind(collider_kind),
		.sts          (sts),
		.new_x        (new_x),
		.new_y        (new_y)
	);

endmodule
